// File: rtl/srrw_pkg.sv
`default_nettype none

package srrw_pkg;

  localparam int SEQ_SPACE   = 256;
  localparam int SEQ_W       = $clog2(SEQ_SPACE);
  localparam int WIN_W       = 5;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int LEN_W       = 10;
  localparam int STAMP_W     = 32;

  localparam logic [WIN_W-1:0] WINDOW_MAX   = WIN_W'(31);
  localparam logic [WIN_W-1:0] RX_WIN_RESET = WIN_W'(1);
  localparam logic [SEQ_W-1:0] LD_RESET     = SEQ_W'(SEQ_SPACE - 1);
  localparam logic [SEQ_W-1:0] CLEAR_LAST   = SEQ_W'(SEQ_SPACE - 1);
  localparam logic [CNT_W-1:0] RUN_MAX      = CNT_W'(MAX_RESULTS - 1);

  typedef enum logic [2:0] {
    K_DELIVER = 3'd0,
    K_ACK     = 3'd1,
    K_NACK    = 3'd2,
    K_FINAL   = 3'd3,
    K_NONE    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    C_SINGLE,
    C_EXPECTED,
    C_IN_WINDOW
  } class_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ONE,
    S_FIRST,
    S_RD,
    S_CHK,
    S_ACK,
    S_DUP
  } state_t;

endpackage

`default_nettype wire

// File: rtl/selective_repeat_receive_window.sv
// Channel   Handshake               Payload
// config    cfg_wr_en               cfg_wr_data (rx_window)
// input     in_valid / in_ready     packet_ok, truncated, seq_in, payload_len, stamp_in
// output    out_valid / out_ready   kind, seq_out, stamp_out, window_out, duplicate, last
//
// After reset every address of the presence map is cleared to zero; no input is taken then.
// One input is worked at a time. A single-result item goes through S_ONE, an in-window
// item through S_DUP. An in-order packet is delivered in S_FIRST; each further delivery
// is a read (S_RD) then a check (S_CHK) of the map RAM, until a check finds the slot
// empty or the run reaches the cap of 31 deliveries; then S_ACK sends the ack.
// States that emit wait while the output register holds a transfer not yet taken.
`default_nettype none

module selective_repeat_receive_window
  import srrw_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_wr_en,
  input  wire [WIN_W-1:0]    cfg_wr_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                packet_ok,
  input  wire                truncated,
  input  wire [SEQ_W-1:0]    seq_in,
  input  wire [LEN_W-1:0]    payload_len,
  input  wire [STAMP_W-1:0]  stamp_in,
  output logic               out_valid,
  input  wire                out_ready,
  output kind_t              kind,
  output logic [SEQ_W-1:0]   seq_out,
  output logic [STAMP_W-1:0] stamp_out,
  output logic [WIN_W-1:0]   window_out,
  output logic               duplicate,
  output logic               last
);

  state_t state, state_next;

  logic [WIN_W-1:0]   rx_window;
  logic [SEQ_W-1:0]   last_delivered;
  logic               transfer_done;
  logic [SEQ_W-1:0]   clr_addr;
  logic [SEQ_W-1:0]   seq_q;
  logic [STAMP_W-1:0] stamp_q;
  kind_t              one_kind;
  logic [SEQ_W-1:0]   run_seq;
  logic [CNT_W-1:0]   run_cnt;

  logic [WIN_W-1:0] win_eff;
  logic [SEQ_W-1:0] seq_dist;
  logic [SEQ_W-1:0] expected;
  class_t           cls;
  kind_t            cls_kind;
  logic             accept;
  logic             slot_free;

  logic               emit;
  kind_t              e_kind;
  logic [SEQ_W-1:0]   e_seq;
  logic [STAMP_W-1:0] e_stamp;
  logic [WIN_W-1:0]   e_win;
  logic               e_dup;
  logic               e_last;

  logic             mem_we;
  logic [SEQ_W-1:0] mem_waddr;
  logic             mem_wdata;
  logic             mem_re;
  logic [SEQ_W-1:0] mem_raddr;
  logic             mem_rdata;

  srrw_ram #(
    .WIDTH(1),
    .DEPTH(SEQ_SPACE)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign win_eff   = (rx_window > WINDOW_MAX) ? WINDOW_MAX : rx_window;
  assign expected  = last_delivered + SEQ_W'(1);
  assign seq_dist  = seq_in - last_delivered;
  assign slot_free = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cls      = C_SINGLE;
    cls_kind = K_NONE;
    if (transfer_done || !packet_ok) begin
      cls_kind = K_NONE;
    end else if (truncated) begin
      cls_kind = K_NACK;
    end else if (payload_len == '0 && seq_in == expected) begin
      cls_kind = K_FINAL;
    end else if (seq_dist == SEQ_W'(1)) begin
      cls = C_EXPECTED;
    end else if (seq_dist != '0 && seq_dist <= {{(SEQ_W-WIN_W){1'b0}}, win_eff}) begin
      cls = C_IN_WINDOW;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == CLEAR_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (cls)
            C_EXPECTED:  state_next = S_FIRST;
            C_IN_WINDOW: state_next = S_DUP;
            default:     state_next = S_ONE;
          endcase
        end
      end
      S_ONE, S_ACK, S_DUP: begin
        if (slot_free) state_next = S_IDLE;
      end
      S_FIRST: begin
        if (slot_free) state_next = S_RD;
      end
      S_RD: begin
        state_next = (run_cnt == RUN_MAX) ? S_ACK : S_CHK;
      end
      S_CHK: begin
        if (!mem_rdata) begin
          state_next = S_ACK;
        end else if (slot_free) begin
          state_next = S_RD;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    emit      = 1'b0;
    e_kind    = K_NONE;
    e_seq     = '0;
    e_stamp   = '0;
    e_win     = '0;
    e_dup     = 1'b0;
    e_last    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = seq_q;
    mem_wdata = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = run_seq;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = seq_in;
        mem_re    = accept && cls == C_IN_WINDOW;
      end
      S_ONE: begin
        emit   = slot_free;
        e_kind = one_kind;
        e_last = 1'b1;
        if (one_kind != K_NONE) begin
          e_stamp = stamp_q;
          e_win   = win_eff;
          e_seq   = (one_kind == K_FINAL) ? seq_q + SEQ_W'(1) : seq_q;
        end
      end
      S_FIRST: begin
        emit   = slot_free;
        e_kind = K_DELIVER;
        e_seq  = seq_q;
        mem_we = slot_free;
      end
      S_RD: begin
        mem_re = run_cnt != RUN_MAX;
      end
      S_CHK: begin
        emit      = mem_rdata && slot_free;
        e_kind    = K_DELIVER;
        e_seq     = run_seq;
        mem_we    = mem_rdata && slot_free;
        mem_waddr = run_seq;
      end
      S_ACK: begin
        emit    = slot_free;
        e_kind  = K_ACK;
        e_seq   = expected;
        e_stamp = stamp_q;
        e_win   = win_eff;
        e_last  = 1'b1;
      end
      S_DUP: begin
        emit      = slot_free;
        e_kind    = K_ACK;
        e_seq     = expected;
        e_stamp   = stamp_q;
        e_win     = win_eff;
        e_dup     = mem_rdata;
        e_last    = 1'b1;
        mem_we    = slot_free;
        mem_wdata = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      rx_window      <= RX_WIN_RESET;
      last_delivered <= LD_RESET;
      transfer_done  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + SEQ_W'(1);
      if (cfg_wr_en) rx_window <= cfg_wr_data;
      if (accept && cls == C_SINGLE && cls_kind == K_FINAL) transfer_done <= 1'b1;
      if (emit && e_kind == K_DELIVER) last_delivered <= e_seq;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_q    <= seq_in;
      stamp_q  <= stamp_in;
      one_kind <= cls_kind;
    end
    if (emit && e_kind == K_DELIVER) begin
      run_seq <= e_seq + SEQ_W'(1);
      run_cnt <= (state == S_FIRST) ? CNT_W'(1) : run_cnt + CNT_W'(1);
    end
    if (emit) begin
      kind       <= e_kind;
      seq_out    <= e_seq;
      stamp_out  <= e_stamp;
      window_out <= e_win;
      duplicate  <= e_dup;
      last       <= e_last;
    end
  end

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("map read and write collide");

  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> run_cnt < RUN_MAX)
    else $error("delivery run beyond cap");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    emit && transfer_done |-> e_kind == K_NONE || e_kind == K_FINAL)
    else $error("response after end of transfer");

  a_ld_follows: assert property (@(posedge clk) disable iff (rst)
    emit && e_kind == K_DELIVER |=> last_delivered == $past(e_seq))
    else $error("last delivered not updated");

endmodule

`default_nettype wire

// File: rtl/srrw_ram.sv
`default_nettype none

module srrw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: verif/selective_repeat_receive_window_checker.sv
`timescale 1ns / 1ps

module selective_repeat_receive_window_checker
  import srrw_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_wr_en,
  input  wire [WIN_W-1:0]    cfg_wr_data,
  input  wire                in_valid,
  input  wire                in_ready,
  input  wire                packet_ok,
  input  wire                truncated,
  input  wire [SEQ_W-1:0]    seq_in,
  input  wire [LEN_W-1:0]    payload_len,
  input  wire [STAMP_W-1:0]  stamp_in,
  input  wire                out_valid,
  input  wire                out_ready,
  input  kind_t              kind,
  input  wire [SEQ_W-1:0]    seq_out,
  input  wire [STAMP_W-1:0]  stamp_out,
  input  wire [WIN_W-1:0]    window_out,
  input  wire                duplicate,
  input  wire                last,
  output logic               busy,
  output logic [SEQ_W-1:0]   expected_next,
  output int                 fail_count
);

  typedef struct packed {
    kind_t              code;
    logic [SEQ_W-1:0]   seq;
    logic [STAMP_W-1:0] stamp;
    logic [WIN_W-1:0]   win;
    logic               dup;
    logic               tail;
  } reply_t;

  reply_t               pending_replies[$];
  logic [WIN_W-1:0]     rx_window     = RX_WIN_RESET;
  logic [SEQ_W-1:0]     delivered_seq = LD_RESET;
  logic [SEQ_SPACE-1:0] buffered      = '0;
  logic                 transfer_over = 1'b0;
  int                   mismatches    = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_reply(input kind_t code, input logic [SEQ_W-1:0] seq,
                            input logic [STAMP_W-1:0] stamp, input logic [WIN_W-1:0] win,
                            input logic dup, input logic tail);
    reply_t r;
    r.code  = code;
    r.seq   = seq;
    r.stamp = stamp;
    r.win   = win;
    r.dup   = dup;
    r.tail  = tail;
    pending_replies.push_back(r);
  endtask

  // Works out the replies to one received header and updates the window state.
  task automatic answer_packet(input logic ok, input logic tr, input logic [SEQ_W-1:0] seq,
                               input logic [LEN_W-1:0] len, input logic [STAMP_W-1:0] stamp);
    logic [WIN_W-1:0] win;
    logic [SEQ_W-1:0] expected;
    logic [SEQ_W-1:0] seq_dist;
    logic [SEQ_W-1:0] s;
    int               n;
    win      = (rx_window > WINDOW_MAX) ? WINDOW_MAX : rx_window;
    expected = delivered_seq + SEQ_W'(1);
    seq_dist = seq - delivered_seq;
    if (transfer_over || !ok) begin
      push_reply(K_NONE, '0, '0, '0, 1'b0, 1'b1);
    end else if (tr) begin
      push_reply(K_NACK, seq, stamp, win, 1'b0, 1'b1);
    end else if (len == '0 && seq == expected) begin
      push_reply(K_FINAL, seq + SEQ_W'(1), stamp, win, 1'b0, 1'b1);
      transfer_over = 1'b1;
    end else if (seq_dist == 8'd1) begin
      s = seq;
      n = 0;
      buffered[s] = 1'b1;
      while (buffered[s] && n < MAX_RESULTS - 1) begin
        buffered[s] = 1'b0;
        push_reply(K_DELIVER, s, '0, '0, 1'b0, 1'b0);
        delivered_seq = s;
        s = s + SEQ_W'(1);
        n++;
      end
      push_reply(K_ACK, delivered_seq + SEQ_W'(1), stamp, win, 1'b0, 1'b1);
    end else if (seq_dist >= 8'd2 && seq_dist <= SEQ_W'(win)) begin
      push_reply(K_ACK, expected, stamp, win, buffered[seq], 1'b1);
      buffered[seq] = 1'b1;
    end else begin
      push_reply(K_NONE, '0, '0, '0, 1'b0, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      rx_window     = RX_WIN_RESET;
      delivered_seq = LD_RESET;
      buffered      = '0;
      transfer_over = 1'b0;
      pending_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer, kind %0d seq %0d", kind, seq_out));
        end else begin
          want = pending_replies.pop_front();
          if (kind !== want.code)
            report_mismatch($sformatf("kind %0d, want %0d", kind, want.code));
          if (seq_out !== want.seq)
            report_mismatch($sformatf("seq_out %0d, want %0d", seq_out, want.seq));
          if (stamp_out !== want.stamp)
            report_mismatch($sformatf("stamp_out %h, want %h", stamp_out, want.stamp));
          if (window_out !== want.win)
            report_mismatch($sformatf("window_out %0d, want %0d", window_out, want.win));
          if (duplicate !== want.dup)
            report_mismatch($sformatf("duplicate %b, want %b", duplicate, want.dup));
          if (last !== want.tail)
            report_mismatch($sformatf("last %b, want %b", last, want.tail));
        end
      end
      if (cfg_wr_en) begin
        rx_window = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        answer_packet(packet_ok, truncated, seq_in, payload_len, stamp_in);
      end
    end
    busy          <= pending_replies.size() != 0;
    expected_next <= delivered_seq + SEQ_W'(1);
    fail_count    <= mismatches;
  end

endmodule

// File: verif/selective_repeat_receive_window_test.sv
`timescale 1ns / 1ps

module selective_repeat_receive_window_test;
  import srrw_pkg::*;

  localparam int ITEM_GOAL   = 480;
  localparam int QUIET_AFTER = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_wr_en   = 1'b0;
  logic [WIN_W-1:0]   cfg_wr_data = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic               packet_ok   = 1'b0;
  logic               truncated   = 1'b0;
  logic [SEQ_W-1:0]   seq_in      = '0;
  logic [LEN_W-1:0]   payload_len = '0;
  logic [STAMP_W-1:0] stamp_in    = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  kind_t              kind;
  logic [SEQ_W-1:0]   seq_out;
  logic [STAMP_W-1:0] stamp_out;
  logic [WIN_W-1:0]   window_out;
  logic               duplicate;
  logic               last;

  logic               busy;
  logic [SEQ_W-1:0]   expected_next;
  int                 fail_count;
  int                 items_sent   = 0;
  int                 stall_cycles = 0;
  logic               quiet        = 1'b0;

  selective_repeat_receive_window i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .packet_ok   (packet_ok),
    .truncated   (truncated),
    .seq_in      (seq_in),
    .payload_len (payload_len),
    .stamp_in    (stamp_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .seq_out     (seq_out),
    .stamp_out   (stamp_out),
    .window_out  (window_out),
    .duplicate   (duplicate),
    .last        (last)
  );

  selective_repeat_receive_window_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .packet_ok     (packet_ok),
    .truncated     (truncated),
    .seq_in        (seq_in),
    .payload_len   (payload_len),
    .stamp_in      (stamp_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .seq_out       (seq_out),
    .stamp_out     (stamp_out),
    .window_out    (window_out),
    .duplicate     (duplicate),
    .last          (last),
    .busy          (busy),
    .expected_next (expected_next),
    .fail_count    (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("selective_repeat_receive_window regression: fail");
      $finish;
    end
  end

  function automatic logic [LEN_W-1:0] rand_len();
    return ($urandom_range(0, 7) == 0) ? LEN_W'(512) : LEN_W'($urandom_range(1, 511));
  endfunction

  task automatic send_packet(input logic ok, input logic tr, input logic [SEQ_W-1:0] seq,
                             input logic [LEN_W-1:0] len, input logic [STAMP_W-1:0] stamp);
    in_valid    <= 1'b1;
    packet_ok   <= ok;
    truncated   <= tr;
    seq_in      <= seq;
    payload_len <= len;
    stamp_in    <= stamp;
    do @(posedge clk); while (!in_ready);
    if (ok) items_sent++;
    if (items_sent >= QUIET_AFTER) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (busy);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] win);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= win;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // end markers only go at or behind the last delivered number, where no run can reach them
  task automatic send_noise(input logic [SEQ_W-1:0] base, input logic [SEQ_W-1:0] seen);
    case ($urandom_range(0, 4))
      0: send_packet(1'b0, 1'($urandom_range(0, 1)), SEQ_W'($urandom),
                     LEN_W'($urandom_range(0, 512)), $urandom);
      1: send_packet(1'b1, 1'b1, SEQ_W'($urandom), LEN_W'($urandom_range(0, 512)), $urandom);
      2: send_packet(1'b1, 1'b0, SEQ_W'($urandom), rand_len(), $urandom);
      3: send_packet(1'b1, 1'b0, base - 1'b1 - SEQ_W'($urandom_range(0, 100)), '0, $urandom);
      default: send_packet(1'b1, 1'b0, seen, rand_len(), $urandom);
    endcase
  endtask

  task automatic run_burst(input logic [WIN_W-1:0] win);
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] order[$];
    logic [SEQ_W-1:0] held;
    int               span;
    int               j;
    int               k;
    base = expected_next;
    if (win == '0) span = 1;
    else if ($urandom_range(0, 3) == 0) span = win;
    else span = $urandom_range(1, win);
    for (j = 0; j < span; j++) order.push_back(base + SEQ_W'(j));
    case ($urandom_range(0, 2))
      0: for (j = 0; j < span / 2; j++) begin
        held = order[j];
        order[j] = order[span - 1 - j];
        order[span - 1 - j] = held;
      end
      1: for (j = span - 1; j > 0; j--) begin
        k = $urandom_range(0, j);
        held = order[j];
        order[j] = order[k];
        order[k] = held;
      end
      default: ;
    endcase
    j = 0;
    while (j < span) begin
      if ($urandom_range(0, 3) == 0) begin
        send_noise(base, order[$urandom_range(0, j)]);
      end else begin
        send_packet(1'b1, 1'b0, order[j], rand_len(), $urandom);
        j++;
      end
    end
  endtask

  initial begin
    logic [WIN_W-1:0] win;
    int               phase;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // window 1 after reset, nothing delivered yet
    send_packet(1'b0, 1'b0, 8'd0, 10'd0, 32'hFFFF_FFFF);
    send_packet(1'b0, 1'b1, 8'hFF, 10'd512, 32'h0);
    send_packet(1'b1, 1'b1, 8'd200, 10'd512, 32'hFFFF_FFFF);
    send_packet(1'b1, 1'b0, 8'd1, 10'd512, $urandom);
    send_packet(1'b1, 1'b0, 8'hFF, 10'd7, $urandom);
    send_packet(1'b1, 1'b0, 8'd0, 10'd512, 32'h0);
    wait_drained();
    set_window('0);
    send_packet(1'b1, 1'b0, 8'd2, 10'd1, $urandom);
    send_packet(1'b1, 1'b0, 8'd1, 10'd1, $urandom);
    wait_drained();
    set_window(WINDOW_MAX);
    send_packet(1'b1, 1'b0, 8'd33, 10'd300, $urandom);
    send_packet(1'b1, 1'b0, 8'd32, 10'd300, $urandom);
    send_packet(1'b1, 1'b0, 8'd32, 10'd300, $urandom);
    send_packet(1'b1, 1'b0, 8'd3, 10'd0, $urandom);
    send_packet(1'b1, 1'b0, 8'd2, 10'd5, $urandom);
    send_packet(1'b1, 1'b1, 8'd4, 10'd0, $urandom);

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      case (phase % 6)
        0: win = WINDOW_MAX;
        1: win = WIN_W'(1);
        2: win = '0;
        default: win = WIN_W'($urandom_range(0, 31));
      endcase
      wait_drained();
      set_window(win);
      run_burst(win);
      phase++;
    end

    // close the transfer, then everything is ignored
    wait_drained();
    send_packet(1'b1, 1'b0, expected_next, '0, $urandom);
    send_packet(1'b1, 1'b0, SEQ_W'($urandom), rand_len(), $urandom);
    send_packet(1'b1, 1'b1, SEQ_W'($urandom), '0, $urandom);
    send_packet(1'b1, 1'b0, SEQ_W'($urandom), '0, $urandom);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && !busy) begin
      $display("selective_repeat_receive_window regression: pass");
    end else begin
      $display("selective_repeat_receive_window regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/srrw_pkg.sv
rtl/srrw_ram.sv
rtl/selective_repeat_receive_window.sv
verif/selective_repeat_receive_window_checker.sv
verif/selective_repeat_receive_window_test.sv
